>>> hdl/positional_list_engine_defines.svh
// Assertion macros for the positional list engine checker.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PLE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ple_pkg.sv
// Shared types, codes and defaults for the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

  localparam int CAPACITY_DEF      = 32;
  localparam int KEY_WIDTH_DEF     = 64;
  localparam int PAYLOAD_WIDTH_DEF = 64;

  localparam int REQ_W    = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_GET    = 3'd2,
    REQ_UPDATE = 3'd3,
    REQ_FIND   = 3'd4
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  position;
    logic              at_end;
    logic [DATA_W-1:0] item_key;
    logic [DATA_W-1:0] item_payload;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    result_position;
    logic [DATA_W-1:0]   key_out;
    logic [DATA_W-1:0]   payload_out;
    logic [COUNT_W-1:0]  count_out;
    logic                list_empty;
  } rsp_item_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] payload;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/ple_ifs.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
`default_nettype none
interface ple_req_if;
  logic                valid;
  logic                ready;
  ple_pkg::req_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ple_rsp_if;
  logic                valid;
  logic                ready;
  ple_pkg::rsp_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/ple_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares its key.
`timescale 1ns / 1ps
`default_nettype none
module ple_cell #(
  parameter int INDEX         = 0,
  parameter int CMP_W         = 6,
  parameter int KEY_WIDTH     = 64,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  wire                      clk,
  input  ple_pkg::cell_ctrl_t      ctrl,
  input  wire [CMP_W-1:0]          tgt,
  input  wire [CMP_W-1:0]          cnt,
  input  wire [KEY_WIDTH-1:0]      left_key,
  input  wire [PAYLOAD_WIDTH-1:0]  left_payload,
  input  wire [KEY_WIDTH-1:0]      right_key,
  input  wire [PAYLOAD_WIDTH-1:0]  right_payload,
  output logic [KEY_WIDTH-1:0]     key,
  output logic [PAYLOAD_WIDTH-1:0] payload,
  output logic                     match
);
  import ple_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX    = CMP_W'(INDEX);
  localparam logic [CMP_W-1:0] MY_IDX_P1 = CMP_W'(INDEX + 1);

  logic [KEY_WIDTH-1:0]     key_next;
  logic [PAYLOAD_WIDTH-1:0] payload_next;

  always_comb begin
    key_next     = key;
    payload_next = payload;
    case (ctrl.op)
      CELL_INSERT: begin
        if (MY_IDX == tgt) begin
          key_next     = ctrl.key[KEY_WIDTH-1:0];
          payload_next = ctrl.payload[PAYLOAD_WIDTH-1:0];
        end else if (MY_IDX > tgt && MY_IDX <= cnt) begin
          key_next     = left_key;
          payload_next = left_payload;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= tgt && MY_IDX_P1 < cnt) begin
          key_next     = right_key;
          payload_next = right_payload;
        end
      end
      CELL_WRITE: begin
        if (MY_IDX == tgt) begin
          key_next     = ctrl.key[KEY_WIDTH-1:0];
          payload_next = ctrl.payload[PAYLOAD_WIDTH-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key     <= key_next;
    payload <= payload_next;
    // Only live entries may report a hit.
    match   <= (key == ctrl.key[KEY_WIDTH-1:0]) && (MY_IDX < cnt);
  end

endmodule
`default_nettype wire

>>> hdl/positional_list_engine.sv
// Top level of the positional list engine: sequencer and row of cells.
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to CAPACITY key/payload entries kept in a row of cells,
// one entry per cell, each cell able to load from its left or right neighbor
// so an insert or delete shifts the whole tail in one step. Requests are
// handled one at a time: the request port reopens at the same edge that
// loads the response into the output register. Each request goes through
// three steps: the cell update (shift, write and key compare in every
// cell), the lowest-match pick, and the read of the selected cell. If the
// response is still waiting to be taken, the last step holds until it is.
// Entry storage needs no clearing after reset; only positions below the
// count are ever read.
module positional_list_engine #(
  parameter int CAPACITY      = ple_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH     = ple_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = ple_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire       clk,
  input  wire       rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);
  import ple_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PICK,
    S_READ
  } state_t;

  state_t              state;
  req_item_t           req_q;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  status_t             status_q;
  status_t             status_next;
  logic [POS_W-1:0]    rpos_q;
  logic [POS_W-1:0]    rpos_next;
  logic                rd_q;
  logic [IDX_W-1:0]    idx_q;
  rsp_item_t           rsp_data;
  logic                rsp_valid;

  cell_ctrl_t          ctrl;
  cell_op_t            op_next;
  logic [CMP_W-1:0]    tgt;
  logic [CMP_W-1:0]    pos_c;
  logic [CMP_W-1:0]    cnt_c;
  logic                full;

  logic [KEY_WIDTH-1:0]     cell_key [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] cell_payload [CAPACITY];
  logic [CAPACITY-1:0]      match;
  logic                     found;
  logic [IDX_W-1:0]         found_idx;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign pos_c = CMP_W'(req_q.position);
  assign cnt_c = CMP_W'(count);
  assign full  = (count == CNT_W'(CAPACITY));

  // Decide the request outcome from the count it finds.
  always_comb begin
    status_next = ST_RANGE;
    rpos_next   = req_q.position;
    op_next     = CELL_HOLD;
    tgt         = pos_c;
    count_next  = count;
    case (req_q.req_type)
      REQ_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
          rpos_next   = req_q.at_end ? '0 : req_q.position;
        end else begin
          tgt = req_q.at_end ? cnt_c : pos_c;
          if (tgt <= cnt_c) begin
            status_next = ST_OK;
            rpos_next   = POS_W'(tgt);
            op_next     = CELL_INSERT;
            count_next  = count + 1'b1;
          end
        end
      end
      REQ_DELETE: begin
        if (pos_c < cnt_c) begin
          status_next = ST_OK;
          op_next     = CELL_DELETE;
          count_next  = count - 1'b1;
        end
      end
      REQ_GET: begin
        if (pos_c < cnt_c) status_next = ST_OK;
      end
      REQ_UPDATE: begin
        if (pos_c < cnt_c) begin
          status_next = ST_OK;
          op_next     = CELL_WRITE;
        end
      end
      REQ_FIND: begin
        status_next = ST_NOTFOUND;
        rpos_next   = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.op      = (state == S_EXEC) ? op_next : CELL_HOLD;
    ctrl.key     = req_q.item_key;
    ctrl.payload = req_q.item_payload;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? 0 : i - 1;
    localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;

    ple_cell #(
      .INDEX         (i),
      .CMP_W         (CMP_W),
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .tgt           (tgt),
      .cnt           (cnt_c),
      .left_key      (cell_key[LEFT]),
      .left_payload  (cell_payload[LEFT]),
      .right_key     (cell_key[RIGHT]),
      .right_payload (cell_payload[RIGHT]),
      .key           (cell_key[i]),
      .payload       (cell_payload[i]),
      .match         (match[i])
    );
  end

  // Lowest hit wins: scan down so the last assignment is the smallest index.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // The read step always leaves a response in the output register.
      if (rsp_valid && rsp.ready && state != S_READ) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_q <= req.data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_q <= status_next;
          rpos_q   <= rpos_next;
          count    <= count_next;
          state    <= S_PICK;
        end
        S_PICK: begin
          if (req_q.req_type == REQ_FIND && found) begin
            status_q <= ST_OK;
            rpos_q   <= POS_W'(found_idx);
            rd_q     <= 1'b1;
            idx_q    <= found_idx;
          end else begin
            rd_q  <= (req_q.req_type == REQ_GET) && (status_q == ST_OK);
            idx_q <= IDX_W'(req_q.position);
          end
          state <= S_READ;
        end
        S_READ: begin
          // Hold until the output register is free.
          if (!rsp_valid || rsp.ready) begin
            rsp_data.status          <= status_q;
            rsp_data.result_position <= rpos_q;
            rsp_data.key_out         <= rd_q ? DATA_W'(cell_key[idx_q]) : '0;
            rsp_data.payload_out     <= rd_q ? DATA_W'(cell_payload[idx_q]) : '0;
            rsp_data.count_out       <= COUNT_W'(count);
            rsp_data.list_empty      <= (count == '0);
            rsp_valid                <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/ple_chk.sv
// Port-level assertions for the positional list engine, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_defines.svh"
module ple_chk (
  input wire                clk,
  input wire                rst,
  input wire                req_valid,
  input wire                req_ready,
  input wire                rsp_valid,
  input wire                rsp_ready,
  input ple_pkg::rsp_item_t rsp_data
);
  import ple_pkg::*;

  `PLE_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")
  `PLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")
  `PLE_ASSERT_IMPL(a_empty_consistent, rsp_valid && rsp_data.list_empty, rsp_data.count_out == 6'd0 && rsp_data.status != ST_FULL, "empty flag disagrees with count or status")
  `PLE_ASSERT_IMPL(a_notfound_clean, rsp_valid && rsp_data.status == ST_NOTFOUND, rsp_data.result_position == 5'd0 && rsp_data.key_out == '0 && rsp_data.payload_out == '0, "miss carries data")
  `PLE_ASSERT_IMPL(a_refused_clean, rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_RANGE), rsp_data.key_out == '0 && rsp_data.payload_out == '0, "refused request carries data")

endmodule

bind positional_list_engine ple_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
`default_nettype wire
